// File: hw/rtl/rwsc_pkg.sv
`default_nettype none

package rwsc_pkg;

  // count and register width
  localparam int CW = 32;
  // intermediate width: the sum of three count-wide terms and its distance to
  // the low bound fit here
  localparam int XW = CW + 3;
  // counter for the serial remainder, holds XW itself
  localparam int CNT_W = $clog2(XW + 1);

  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_RANGE_LOW  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RANGE_HIGH = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LIMIT_MODE = IDX_W'(2);

  localparam logic MODE_WRAP     = 1'b0;
  localparam logic MODE_SATURATE = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/rwsc_rem_serial.sv
`default_nettype none

// restoring remainder, one dividend bit per cycle, msb first
module rwsc_rem_serial import rwsc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] dividend,
  input  logic [XW-1:0] divisor,
  output logic          done,
  output logic [XW-1:0] remainder
);

  logic [XW-1:0]    dvd;
  logic [XW-1:0]    dvs;
  logic [XW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [XW-1:0]    rem_shift;
  logic [XW:0]      diff;

  assign rem_shift = {rem[XW-2:0], dvd[XW-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(XW);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[XW-2:0], 1'b0};
      // keep the shifted value when the divisor does not fit
      rem <= diff[XW] ? rem_shift : diff[XW-1:0];
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !running)
    else $error("remainder unit started while busy");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    running |-> (cnt != '0))
    else $error("remainder unit running with empty count");

endmodule

`default_nettype wire

// File: hw/rtl/range_wrap_saturate_counter_unit.sv
`default_nettype none

// Signed up/down counter held inside a configured range [range_low, range_high].
// Input channel (in_valid / in_stall): one word carries the up, down and load
// flags with their amounts; a word is taken when in_valid is high and in_stall
// low. The block raises in_stall while it works on a word.
// Output channel (out_valid / out_stall): one word per input word, the new
// count. The result sits in an output register until taken, so a stalled
// receiver only holds up the next result, not the next input word.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 low
// bound, 1 high bound, 2 mode (0 wrap, 1 saturate); cfg_ready is always high.
// From input to output register a word passes the clamp, up, down and range
// steps and then the done step; an empty range goes from the clamp step
// straight to done, and a wrap adds the divide, fix and add steps. The divide
// step runs the serial remainder unit, which takes one dividend bit per cycle
// over the 35-bit intermediate. The next input word is taken the cycle after
// the result enters the output register; no new word is taken before that.
// Reset clears the count to 0, the bounds to 0 and 10, the mode to wrap, and
// empties the output register.
module range_wrap_saturate_counter_unit import rwsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  up_flag,
  input  logic signed [CW-1:0]  up_amount,
  input  logic                  down_flag,
  input  logic signed [CW-1:0]  down_amount,
  input  logic                  load_flag,
  input  logic signed [CW-1:0]  load_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [CW-1:0]  count_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CW-1:0]         cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLAMP = 9'b000000010,
    ST_UP    = 9'b000000100,
    ST_DOWN  = 9'b000001000,
    ST_RANGE = 9'b000010000,
    ST_DIV   = 9'b000100000,
    ST_FIX   = 9'b001000000,
    ST_ADD   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  function automatic logic [XW-1:0] sext(input logic [CW-1:0] x);
    sext = {{(XW-CW){x[CW-1]}}, x};
  endfunction

  state_t        state;
  logic [CW-1:0] range_low;
  logic [CW-1:0] range_high;
  logic          limit_mode;
  logic [CW-1:0] count_value;

  logic          up_f;
  logic          down_f;
  logic          load_f;
  logic [CW-1:0] up_amt;
  logic [CW-1:0] down_amt;
  logic [CW-1:0] load_val;

  logic [XW-1:0] v;
  logic [XW-1:0] span;
  logic          neg;
  logic [XW-1:0] lo_x;
  logic [XW-1:0] hi_x;
  logic          v_above;
  logic          v_below;
  logic          out_free;
  logic          in_take;

  logic          div_start;
  logic          div_done;
  logic [XW-1:0] div_rem;
  logic [XW-1:0] div_dividend;

  assign lo_x      = sext(range_low);
  assign hi_x      = sext(range_high);
  assign v_above   = $signed(v) > $signed(hi_x);
  assign v_below   = $signed(v) < $signed(lo_x);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // distance to the low bound, as a magnitude
  assign div_dividend = v_below ? (lo_x - v) : (v - lo_x);
  assign div_start    = (state == ST_RANGE) && (limit_mode == MODE_WRAP) &&
                        (v_above || v_below);

  rwsc_rem_serial u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (span),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= CW'(10);
      limit_mode <= MODE_WRAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        REG_LIMIT_MODE: limit_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      up_f     <= up_flag;
      down_f   <= down_flag;
      load_f   <= load_flag;
      up_amt   <= up_amount;
      down_amt <= down_amount;
      load_val <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      // a word posted in the done step replaces the one taken this cycle
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if ($signed(range_high) < $signed(range_low)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_UP;
          end
        end
        ST_UP:    state <= ST_DOWN;
        ST_DOWN:  state <= ST_RANGE;
        ST_RANGE: begin
          if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX:   state <= ST_ADD;
        ST_ADD:   state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            count_value <= v[CW-1:0];
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      count_out <= v[CW-1:0];
    end
  end

  // datapath with the wide adds and compares of each step
  always_ff @(posedge clk) begin
    unique case (state)
      ST_CLAMP: begin
        span <= hi_x - lo_x + XW'(1);
        if ($signed(range_high) < $signed(range_low)) begin
          v <= lo_x;
        end else if ($signed(count_value) > $signed(range_high)) begin
          v <= hi_x;
        end else if ($signed(count_value) < $signed(range_low)) begin
          v <= lo_x;
        end else begin
          v <= sext(count_value);
        end
      end
      ST_UP: begin
        if (up_f) begin
          v <= v + sext(up_amt);
        end
      end
      ST_DOWN: begin
        if (load_f) begin
          v <= sext(load_val);
        end else if (down_f) begin
          v <= v - sext(down_amt);
        end
      end
      ST_RANGE: begin
        neg <= v_below;
        if (limit_mode == MODE_SATURATE) begin
          if (v_above) begin
            v <= hi_x;
          end else if (v_below) begin
            v <= lo_x;
          end
        end
      end
      ST_FIX: begin
        // below the range the offset counts back from the top
        if (neg && (div_rem != '0)) begin
          v <= span - div_rem;
        end else begin
          v <= div_rem;
        end
      end
      ST_ADD: begin
        v <= v + lo_x;
      end
      default: ;
    endcase
  end

  a_done_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |->
      (($signed(v) >= $signed(lo_x)) && ($signed(v) <= $signed(hi_x))) ||
      (($signed(range_high) < $signed(range_low)) && (v == lo_x)))
    else $error("result outside configured range");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_CLAMP))
    else $error("accepted word did not start processing");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("remainder finished outside the divide step");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (out_valid && (state == ST_IDLE) &&
      (count_out == count_value)))
    else $error("result not posted to output register");

endmodule

`default_nettype wire

// File: tb/sv/range_wrap_saturate_counter_unit_tb.sv
`default_nettype none

module range_wrap_saturate_counter_unit_tb import rwsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
  // index with no register behind it, writes there must leave everything alone
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(3);
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 14;
  localparam int WORDS_PER_PHASE = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic up_flag = 1'b0;
  logic signed [CW-1:0] up_amount = '0;
  logic down_flag = 1'b0;
  logic signed [CW-1:0] down_amount = '0;
  logic load_flag = 1'b0;
  logic signed [CW-1:0] load_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] count_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  // predictor state, mirrors the block after reset
  logic signed [CW-1:0] bound_low = '0;
  logic signed [CW-1:0] bound_high = CW'(10);
  logic sat_mode = MODE_WRAP;
  logic signed [CW-1:0] count_now = '0;

  logic signed [CW-1:0] count_due[$];
  logic signed [CW-1:0] due;
  int mismatches = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  range_wrap_saturate_counter_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .up_flag(up_flag),
    .up_amount(up_amount),
    .down_flag(down_flag),
    .down_amount(down_amount),
    .load_flag(load_flag),
    .load_value(load_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count_out(count_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // exact arithmetic in 64 bits, the three terms never overflow it
  function automatic logic signed [CW-1:0] next_count(
    input logic u, input logic signed [CW-1:0] ua,
    input logic d, input logic signed [CW-1:0] da,
    input logic l, input logic signed [CW-1:0] lv);
    longint lo, hi, v, span, r;
    lo = bound_low;
    hi = bound_high;
    v = count_now;
    if (hi < lo) begin
      v = lo;
    end else begin
      // stored count may be stale after a range change
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      if (u) v = v + ua;
      if (d) v = v - da;
      if (l) v = lv;
      if (sat_mode == MODE_SATURATE) begin
        if (v > hi) v = hi;
        if (v < lo) v = lo;
      end else if (v > hi || v < lo) begin
        span = hi - lo + 1;
        r = (v - lo) % span;
        if (r < 0) r = r + span;
        v = lo + r;
      end
    end
    return v[CW-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CW-1:0] pick_value(input longint lo, input longint hi);
    longint v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = longint'($urandom_range(0, 80)) - 40;
      4, 5: v = ($urandom_range(0, 1) ? hi : lo) + longint'($urandom_range(0, 6)) - 3;
      // around one span, lands near the wrap points
      6: v = hi - lo + longint'($urandom_range(0, 2));
      7: begin
        case ($urandom_range(0, 3))
          0: v = CNT_MIN;
          1: v = CNT_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = longint'($signed($urandom));
    endcase
    return v[CW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  task automatic send_word(
    input logic u, input logic signed [CW-1:0] ua,
    input logic d, input logic signed [CW-1:0] da,
    input logic l, input logic signed [CW-1:0] lv);
    int gap;
    logic signed [CW-1:0] nxt;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    up_flag <= u;
    up_amount <= ua;
    down_flag <= d;
    down_amount <= da;
    load_flag <= l;
    load_value <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    nxt = next_count(u, ua, d, da, l, lv);
    count_due.push_back(nxt);
    count_now = nxt;
  endtask

  // block is idle once every count has come back, every word has a result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (count_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RANGE_LOW: bound_low = data;
      REG_RANGE_HIGH: bound_high = data;
      REG_LIMIT_MODE: sat_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(input longint lo, input longint hi, input logic m,
                           input logic junk, input logic poke_unused);
    logic [CW-2:0] upper;
    wait_idle();
    // only bit 0 of the mode word counts
    upper = junk ? (CW-1)'($urandom) : '0;
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    write_reg(REG_RANGE_LOW, lo[CW-1:0]);
    write_reg(REG_RANGE_HIGH, hi[CW-1:0]);
    write_reg(REG_LIMIT_MODE, {upper, m});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_range();
    send_word(1'b0, '0, 1'b0, '0, 1'b0, '0);
    send_word(1'b1, CW'(7), 1'b0, '0, 1'b0, '0);
    send_word(1'b1, CW'(5), 1'b0, '0, 1'b0, '0);
    send_word(1'b0, '0, 1'b1, CW'(3), 1'b0, '0);
    send_word(1'b0, '0, 1'b0, '0, 1'b1, CW'(25));
    send_word(1'b0, '0, 1'b0, '0, 1'b1, CW'(-1));
    send_word(1'b1, CNT_MAX, 1'b1, CNT_MIN, 1'b1, CW'(4));
  endtask

  task automatic test_full_range();
    configure(CNT_MIN, CNT_MAX, MODE_WRAP, 1'b0, 1'b0);
    send_word(1'b0, '0, 1'b0, '0, 1'b1, CNT_MAX);
    send_word(1'b1, CNT_MAX, 1'b0, '0, 1'b0, '0);
    send_word(1'b1, CNT_MIN, 1'b1, CNT_MAX, 1'b0, '0);
    send_word(1'b1, CNT_MAX, 1'b1, CNT_MIN, 1'b0, '0);
    configure(CNT_MIN, CNT_MAX, MODE_SATURATE, 1'b0, 1'b0);
    send_word(1'b1, CNT_MAX, 1'b1, CNT_MIN, 1'b0, '0);
    send_word(1'b1, CNT_MAX, 1'b0, '0, 1'b0, '0);
    send_word(1'b1, CNT_MIN, 1'b1, CNT_MAX, 1'b0, '0);
    send_word(1'b0, '0, 1'b1, CW'(-1), 1'b0, '0);
  endtask

  task automatic test_empty_and_single();
    configure(20, -20, MODE_WRAP, 1'b0, 1'b0);
    send_word(1'b1, CW'(3), 1'b1, CW'(9), 1'b1, CW'(-100));
    configure(20, -20, MODE_SATURATE, 1'b1, 1'b0);
    send_word(1'b1, CNT_MAX, 1'b0, '0, 1'b0, '0);
    configure(-7, -7, MODE_WRAP, 1'b0, 1'b0);
    send_word(1'b1, CW'(123), 1'b0, '0, 1'b0, '0);
  endtask

  task automatic test_stale_count();
    configure(0, 100, MODE_WRAP, 1'b0, 1'b1);
    send_word(1'b0, '0, 1'b0, '0, 1'b1, CW'(90));
    // count now above the new high bound: clamps, no wrap
    configure(0, 50, MODE_WRAP, 1'b0, 1'b1);
    send_word(1'b0, '0, 1'b0, '0, 1'b0, '0);
    configure(60, 70, MODE_WRAP, 1'b1, 1'b0);
    send_word(1'b0, '0, 1'b1, CW'(1), 1'b0, '0);
  endtask

  task automatic test_random_phases();
    longint lo, hi;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          lo = longint'($urandom_range(0, 100)) - 50;
          hi = lo + $urandom_range(0, 30);
        end
        5: begin
          lo = longint'($signed($urandom));
          hi = longint'($signed($urandom));
        end
        6: begin
          case ($urandom_range(0, 2))
            0: begin lo = CNT_MIN; hi = CNT_MAX; end
            1: begin lo = CNT_MIN; hi = longint'(CNT_MIN) + $urandom_range(0, 3); end
            default: begin hi = CNT_MAX; lo = longint'(CNT_MAX) - $urandom_range(0, 3); end
          endcase
        end
        7: begin
          lo = longint'($urandom_range(0, 200)) - 100;
          hi = lo - $urandom_range(1, 5);
        end
        default: begin
          lo = longint'($signed($urandom)) >>> 8;
          hi = lo + $urandom_range(0, 5000);
        end
      endcase
      configure(lo, hi, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 1'b0);
      calm = ($urandom_range(0, 3) == 0);
      repeat (WORDS_PER_PHASE) begin
        send_word(1'($urandom_range(0, 1)), pick_value(lo, hi),
                  1'($urandom_range(0, 1)), pick_value(lo, hi),
                  $urandom_range(0, 3) == 0, pick_value(lo, hi));
      end
      calm = 1'b0;
    end
  endtask

  // result side: check each word taken, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (count_due.size() == 0) begin
        report_mismatch($sformatf("count %0d with nothing pending", count_out));
      end else begin
        due = count_due.pop_front();
        if (count_out !== due)
          report_mismatch($sformatf("count_out expected %0d got %0d", due, count_out));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_range();
    test_full_range();
    test_empty_and_single();
    test_stale_count();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/rwsc_pkg.sv
hw/rtl/rwsc_rem_serial.sv
hw/rtl/range_wrap_saturate_counter_unit.sv
tb/sv/range_wrap_saturate_counter_unit_tb.sv
